>>> hw/rtl/hmp_pkg.sv
// Package for the message padder: item types, controller states and datapath commands.
package hmp_pkg;

  // Width of the message byte counter; the bit length is this count times eight.
  localparam int unsigned ByteCountWidth = 61;

  // Word position within a 512-bit block that holds the low length word.
  localparam logic [3:0] LengthLowSlot = 4'd14;
  localparam logic [3:0] LastSlot      = 4'd15;

  // Padding byte that follows the last message byte.
  localparam logic [7:0] PadByte = 8'h80;

  // Input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       final_item;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [31:0] word;
    logic        block_end;
    logic        message_end;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StZero,
    StLenHi
  } state_e;

  // Source of the word loaded into the output register.
  typedef enum logic [2:0] {
    SrcData,
    SrcPad,
    SrcZero,
    SrcLenLo,
    SrcLenHi
  } word_src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      accept;
    logic      load;
    word_src_e src;
    logic      clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic word_full;
    logic slot_is_len;
  } status_t;

endpackage

>>> hw/rtl/hmp_ctrl.sv
// Controller state machine of the message padder.
module hmp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              final_item_i,
  input  hmp_pkg::status_t  status_i,
  output hmp_pkg::cmd_t     cmd_o,
  output logic              in_stall_o
);

  hmp_pkg::state_e state_q, state_d;
  logic            take;

  // An item is taken only in idle and only when the output register can load.
  assign take       = in_valid_i && (state_q == hmp_pkg::StIdle) && status_i.out_free;
  assign in_stall_o = !((state_q == hmp_pkg::StIdle) && status_i.out_free);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      hmp_pkg::StIdle: begin
        if (take && final_item_i) begin
          state_d = hmp_pkg::StPad;
        end
      end
      hmp_pkg::StPad: begin
        if (status_i.out_free) begin
          state_d = hmp_pkg::StZero;
        end
      end
      hmp_pkg::StZero: begin
        if (status_i.out_free && status_i.slot_is_len) begin
          state_d = hmp_pkg::StLenHi;
        end
      end
      hmp_pkg::StLenHi: begin
        if (status_i.out_free) begin
          state_d = hmp_pkg::StIdle;
        end
      end
      default: state_d = hmp_pkg::StIdle;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o.accept = take;
    cmd_o.load   = 1'b0;
    cmd_o.src    = hmp_pkg::SrcData;
    cmd_o.clear  = 1'b0;
    case (state_q)
      hmp_pkg::StIdle: begin
        cmd_o.load = take && status_i.word_full;
        cmd_o.src  = hmp_pkg::SrcData;
      end
      hmp_pkg::StPad: begin
        cmd_o.load = status_i.out_free;
        cmd_o.src  = hmp_pkg::SrcPad;
      end
      hmp_pkg::StZero: begin
        cmd_o.load = status_i.out_free;
        cmd_o.src  = status_i.slot_is_len ? hmp_pkg::SrcLenLo : hmp_pkg::SrcZero;
      end
      hmp_pkg::StLenHi: begin
        cmd_o.load  = status_i.out_free;
        cmd_o.src   = hmp_pkg::SrcLenHi;
        cmd_o.clear = status_i.out_free;
      end
      default: begin
        cmd_o.load = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hmp_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/hmp_datapath.sv
// Datapath of the message padder: word packing, counters, length and output register.
module hmp_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hmp_pkg::in_item_t   in_item_i,
  input  hmp_pkg::cmd_t       cmd_i,
  output hmp_pkg::status_t    status_o,
  output logic                out_valid_o,
  output hmp_pkg::out_item_t  out_item_o,
  input  logic                out_stall_i
);

  logic [31:0]                          partial_q, partial_d;
  logic [1:0]                           byte_slot_q, byte_slot_d;
  logic [3:0]                           word_slot_q, word_slot_d;
  logic [hmp_pkg::ByteCountWidth-1:0]   byte_total_q, byte_total_d;
  logic                                 out_valid_q, out_valid_d;
  hmp_pkg::out_item_t                   out_item_q, out_item_d;
  logic [4:0]                           shift_amt;
  logic [31:0]                          with_byte;
  logic [31:0]                          with_pad;
  logic [63:0]                          bit_length;
  logic [31:0]                          word_sel;

  // Byte insertion and padding, first byte in the low bits.
  assign shift_amt  = {byte_slot_q, 3'b000};
  assign with_byte  = partial_q | (32'(in_item_i.data_byte) << shift_amt);
  assign with_pad   = partial_q | (32'(hmp_pkg::PadByte) << shift_amt);
  assign bit_length = 64'(byte_total_q) << 3;

  // Status towards the controller.
  assign status_o.out_free    = !out_valid_q || !out_stall_i;
  assign status_o.word_full   = in_item_i.byte_present && (byte_slot_q == 2'd3);
  assign status_o.slot_is_len = (word_slot_q == hmp_pkg::LengthLowSlot);

  // Word selection for the output register.
  always_comb begin
    case (cmd_i.src)
      hmp_pkg::SrcData:  word_sel = with_byte;
      hmp_pkg::SrcPad:   word_sel = with_pad;
      hmp_pkg::SrcZero:  word_sel = 32'd0;
      hmp_pkg::SrcLenLo: word_sel = bit_length[31:0];
      hmp_pkg::SrcLenHi: word_sel = bit_length[63:32];
      default:           word_sel = 32'd0;
    endcase
  end

  // Message state updates.
  always_comb begin
    partial_d    = partial_q;
    byte_slot_d  = byte_slot_q;
    word_slot_d  = word_slot_q;
    byte_total_d = byte_total_q;
    if (cmd_i.accept && in_item_i.byte_present) begin
      byte_slot_d  = byte_slot_q + 2'd1;
      byte_total_d = byte_total_q + {{(hmp_pkg::ByteCountWidth-1){1'b0}}, 1'b1};
      partial_d    = (byte_slot_q == 2'd3) ? 32'd0 : with_byte;
    end
    if (cmd_i.load) begin
      word_slot_d = word_slot_q + 4'd1;
    end
    if (cmd_i.clear) begin
      partial_d    = '0;
      byte_slot_d  = '0;
      word_slot_d  = '0;
      byte_total_d = '0;
    end
  end

  // Output register: loads on command, empties when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (cmd_i.load) begin
      out_valid_d             = 1'b1;
      out_item_d.word         = word_sel;
      out_item_d.block_end    = (word_slot_q == hmp_pkg::LastSlot);
      out_item_d.message_end  = (cmd_i.src == hmp_pkg::SrcLenHi);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q    <= '0;
      byte_slot_q  <= '0;
      word_slot_q  <= '0;
      byte_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      partial_q    <= partial_d;
      byte_slot_q  <= byte_slot_d;
      word_slot_q  <= word_slot_d;
      byte_total_q <= byte_total_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  // The low length word always lands on word 14 of its block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && (cmd_i.src == hmp_pkg::SrcLenLo) |-> word_slot_q == hmp_pkg::LengthLowSlot)
    else $error("low length word not at word 14");

  // The high length word closes a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && (cmd_i.src == hmp_pkg::SrcLenHi) |-> word_slot_q == hmp_pkg::LastSlot)
    else $error("high length word not at word 15");

  // After the message the byte total, word slot and byte slot are back at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (byte_total_q == '0) && (word_slot_q == 4'd0) && (byte_slot_q == 2'd0))
    else $error("state not cleared after message");

  // The output register never loads over an item still waiting to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || !out_stall_i))
    else $error("output item overwritten");
`endif

endmodule

>>> hw/rtl/hash_message_padder_top.sv
// Top level of the MD5 message padder: controller and datapath.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+--------------------------
//   in       | input     | in_valid_i/in_stall_o  | hmp_pkg::in_item_t
//   out      | output    | out_valid_o/out_stall_i| hmp_pkg::out_item_t
//
// Byte items can follow back to back while the output is taken.
// A final item is followed by 3 to 18 padding and length words, one per cycle while the output
// is taken, from the controller's padding sequence, during which the input is stalled.
// Reset clears all counters and the output valid; the block is then ready for a message.
// An output stall holds the output register and stalls the input and the padding sequence.
module hash_message_padder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hmp_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hmp_pkg::out_item_t  out_item_o
);

  hmp_pkg::cmd_t    cmd;
  hmp_pkg::status_t status;

  // Sequencing of input, padding and length words.
  hmp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .final_item_i (in_item_i.final_item),
    .status_i     (status),
    .cmd_o        (cmd),
    .in_stall_o   (in_stall_o)
  );

  // Word packing, counters and output register.
  hmp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule
